@@ src/mbps_pkg.sv @@
package mbps_pkg;

   // Window depth and the width of the stream byte counter.
   localparam int MAX_PATTERN = 16;
   localparam int OFFSET_BITS = 32;

   // The pattern registers hold sixteen bytes.
   localparam int REG_BYTES     = 16;
   localparam int PATTERN_LIMIT = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

   localparam int LEN_BITS     = 5;
   localparam int WIN_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int NUMBER_BITS  = 32;
   localparam int RESULT_BITS  = 32;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = '1;

   localparam logic [15:0]         CARE_MASK_RESET = 16'hFFFF;
   localparam logic [LEN_BITS-1:0] LENGTH_RESET    = LEN_BITS'(1);

   typedef enum logic [1:0] {
      REG_PATTERN_LOW  = 2'd0,
      REG_PATTERN_HIGH = 2'd1,
      REG_CARE_MASK    = 2'd2,
      REG_LENGTH       = 2'd3
   } reg_index_type;

   typedef logic [MAX_PATTERN-1:0][7:0] window_type;

   typedef struct packed {
      logic [63:0]         pattern_high;
      logic [63:0]         pattern_low;
      logic [15:0]         care_mask;
      logic [LEN_BITS-1:0] length;
   } cfg_type;

   typedef struct packed {
      logic                   found;
      logic [RESULT_BITS-1:0] match_offset;
      logic [NUMBER_BITS-1:0] match_number;
   } result_type;

   typedef struct packed {
      window_type             window;
      logic [OFFSET_BITS-1:0] bytes_seen;
      logic [NUMBER_BITS-1:0] matches_seen;
      logic                   emit;
      result_type             result;
   } match_out_type;

endpackage

@@ src/mbps_match.sv @@
module mbps_match
   import mbps_pkg::*;
(
   input  cfg_type                cfg,
   input  window_type             window,
   input  logic [OFFSET_BITS-1:0] bytes_seen,
   input  logic [NUMBER_BITS-1:0] matches_seen,
   input  logic [7:0]             data_byte,
   input  logic                   first_byte,
   input  logic                   last_byte,
   output match_out_type          next
);

   logic [LEN_BITS-1:0]    len;
   logic [8*REG_BYTES-1:0] pattern;
   window_type             window_new;
   logic [OFFSET_BITS-1:0] bytes_new;
   logic [NUMBER_BITS-1:0] matches_cur;
   logic [LEN_BITS-1:0]    pos;
   logic                   match;

   always_comb begin
      if (cfg.length == '0) begin
         len = LEN_BITS'(1);
      end else if (cfg.length > LEN_BITS'(PATTERN_LIMIT)) begin
         len = LEN_BITS'(PATTERN_LIMIT);
      end else begin
         len = cfg.length;
      end

      pattern = {cfg.pattern_high, cfg.pattern_low};

      // A new stream starts from an empty window and zero counters.
      window_new[0] = data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_new[i] = first_byte ? 8'h00 : window[i-1];
      end

      if (first_byte) begin
         bytes_new   = OFFSET_BITS'(1);
         matches_cur = '0;
      end else begin
         bytes_new   = (bytes_seen != OFFSET_MAX) ? bytes_seen + OFFSET_BITS'(1) : bytes_seen;
         matches_cur = matches_seen;
      end

      // Pattern byte i lines up with the window byte len-1-i places back.
      match = (bytes_new >= OFFSET_BITS'(len));
      pos   = '0;
      for (int i = 0; i < PATTERN_LIMIT; i++) begin
         pos = len - LEN_BITS'(1) - LEN_BITS'(i);
         if ((LEN_BITS'(i) < len) && cfg.care_mask[i] &&
             (window_new[pos[WIN_IDX_BITS-1:0]] != pattern[8*i +: 8])) begin
            match = 1'b0;
         end
      end

      next.window     = window_new;
      next.bytes_seen = bytes_new;
      next.emit       = match || (last_byte && (matches_cur == '0));
      next.result.found = match;
      if (match) begin
         next.result.match_offset = RESULT_BITS'(bytes_new - OFFSET_BITS'(len));
         next.result.match_number = matches_cur;
         next.matches_seen = (matches_cur != NUMBER_MAX) ?
                             matches_cur + NUMBER_BITS'(1) : matches_cur;
      end else begin
         next.result.match_offset = '0;
         next.result.match_number = '0;
         next.matches_seen        = matches_cur;
      end
   end

endmodule

@@ src/mbps_skid.sv @@
module mbps_skid
   import mbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       push;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign push      = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         // The output register is free this cycle: the older word goes first.
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid word not moved to output register");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_data_ff == $past(skid_data_ff)))
      else $error("word order lost between skid and output register");

endmodule

@@ src/masked_byte_pattern_scanner.sv @@
// Channel   Direction  Word contents
// req_*     in         tdata[7:0] data_byte, tuser first_byte, tlast last_byte
// rsp_*     out        tdata[31:0] match_offset, tdata[63:32] match_number,
//                      tuser found
// csr_*     in         64-bit registers at 0, 8, 16, 24: pattern low, pattern high,
//                      care mask, pattern length
//
// One byte is accepted per clock while the buffer has room; each result is registered.
// Up to sixteen window bytes are compared, masked, in the cycle the byte is taken.
// Reset clears the window, both counters and the registers to their reset values.
// A two-word output buffer lets input continue while one result waits; input
// stalls only when both words are held.
module masked_byte_pattern_scanner
   import mbps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // match_offset [31:0], match_number [63:32]
   output logic        rsp_tuser,   // found
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type                cfg_ff, cfg_in;
   window_type             window_ff;
   logic [OFFSET_BITS-1:0] bytes_seen_ff;
   logic [NUMBER_BITS-1:0] matches_seen_ff;
   match_out_type          step;
   reg_index_type          reg_index;
   logic                   csr_write;
   logic                   accept;
   logic                   buf_ready;
   result_type             rsp_word;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = reg_index_type'(csr_paddr[4:3]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_PATTERN_LOW:  cfg_in.pattern_low  = csr_pwdata;
            REG_PATTERN_HIGH: cfg_in.pattern_high = csr_pwdata;
            REG_CARE_MASK:    cfg_in.care_mask    = csr_pwdata[15:0];
            REG_LENGTH:       cfg_in.length       = csr_pwdata[LEN_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LOW:  csr_prdata = cfg_ff.pattern_low;
         REG_PATTERN_HIGH: csr_prdata = cfg_ff.pattern_high;
         REG_CARE_MASK:    csr_prdata = 64'(cfg_ff.care_mask);
         REG_LENGTH:       csr_prdata = 64'(cfg_ff.length);
         default:          csr_prdata = '0;
      endcase
   end

   mbps_match u_match (
      .cfg          (cfg_ff),
      .window       (window_ff),
      .bytes_seen   (bytes_seen_ff),
      .matches_seen (matches_seen_ff),
      .data_byte    (req_tdata),
      .first_byte   (req_tuser),
      .last_byte    (req_tlast),
      .next         (step)
   );

   // Every word is taken while the buffer has room, whether it yields a result or not.
   assign req_tready = buf_ready;
   assign accept     = req_tvalid && buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low  <= '0;
         cfg_ff.pattern_high <= '0;
         cfg_ff.care_mask    <= CARE_MASK_RESET;
         cfg_ff.length       <= LENGTH_RESET;
         window_ff           <= '0;
         bytes_seen_ff       <= '0;
         matches_seen_ff     <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            window_ff       <= step.window;
            bytes_seen_ff   <= step.bytes_seen;
            matches_seen_ff <= step.matches_seen;
         end
      end
   end

   mbps_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && step.emit),
      .in_ready  (buf_ready),
      .in_data   (step.result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_word)
   );

   assign rsp_tdata = {rsp_word.match_number, rsp_word.match_offset};
   assign rsp_tuser = rsp_word.found;

   a_bytes_counted: assert property (@(posedge clock) disable iff (reset)
      accept |=> (bytes_seen_ff != '0))
      else $error("byte counter zero after a byte was taken");

   a_matches_monotonic: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tuser) |=> (matches_seen_ff >= $past(matches_seen_ff)))
      else $error("match counter went backward within a stream");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      (!accept && !$past(reset)) |=> ($stable(window_ff) && $stable(bytes_seen_ff)))
      else $error("window or byte counter changed without a byte");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (accept && step.emit && step.result.found) |=>
         (matches_seen_ff != '0))
      else $error("match reported but not counted");

endmodule
